[src/gpio_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO port package
// Types, register numbers and helper functions shared by the GPIO port block.
// ----------------------------------------------------------------------------
package gpio_pkg;

   localparam int unsigned PIN_COUNT = 16;
   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned KEY_BIT = 16;

   localparam logic [WORD_WIDTH-1:0] CFG_RESET = 32'h4444_4444;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [2:0] REG_CFG_LOW = 3'd0;
   localparam logic [2:0] REG_CFG_HIGH = 3'd1;
   localparam logic [2:0] REG_INPUT_DATA = 3'd2;
   localparam logic [2:0] REG_OUTPUT_DATA = 3'd3;
   localparam logic [2:0] REG_SET_RESET = 3'd4;
   localparam logic [2:0] REG_RESET = 3'd5;
   localparam logic [2:0] REG_LOCK = 3'd6;

   typedef struct packed {
      logic                  kind;
      logic [2:0]            reg_select;
      logic [WORD_WIDTH-1:0] write_data;
      logic [PIN_COUNT-1:0]  pin_levels;
   } gpio_access_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] read_data;
      logic [PIN_COUNT-1:0]  pin_drive;
      logic [WORD_WIDTH-1:0] config_low_word;
      logic [WORD_WIDTH-1:0] config_high_word;
      logic                  lock_engaged;
   } gpio_result_type;

   // Widens eight pin bits into a mask over their four-bit config fields.
   function automatic logic [WORD_WIDTH-1:0] nibble_mask(input logic [7:0] pins);
      logic [WORD_WIDTH-1:0] mask;
      mask = '0;
      for (int i = 0; i < 8; i++) begin
         mask[4*i +: 4] = {4{pins[i]}};
      end
      return mask;
   endfunction

endpackage

[src/gpio_port_register_block_core.sv]
// ----------------------------------------------------------------------------
// GPIO port register block
// Sixteen-pin GPIO port with config, data, bit set/reset and lock registers.
// ----------------------------------------------------------------------------
// Each request on the req_ channel is one read or write of a port register,
// together with the sampled pin levels. Each request yields exactly one
// response on the rsp_ channel carrying the read data (zero for writes) and
// the pin drive, config words and lock flag as they stand after the request.
// A request is taken at a clock edge where req_valid is high and req_stall
// is low; a response is taken likewise on rsp_valid and rsp_stall.
// The request is registered at acceptance. Once the response register is
// free, the registers are updated and the response is registered together.
// One request is accepted every cycle while the receiver takes responses;
// the register update is a read-modify-write of the registered request.
// While the receiver stalls, the response holds and one further request is
// buffered in the request register; req_stall then rises until the response
// is taken. Reset clears both stages, sets the config words to floating
// inputs, clears the output data, and disarms and releases the lock.
// ----------------------------------------------------------------------------
module gpio_port_register_block_core
   import gpio_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [2:0]            req_reg_select,
   input  logic [WORD_WIDTH-1:0] req_write_data,
   input  logic [PIN_COUNT-1:0]  req_pin_levels,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [WORD_WIDTH-1:0] rsp_read_data,
   output logic [PIN_COUNT-1:0]  rsp_pin_drive,
   output logic [WORD_WIDTH-1:0] rsp_config_low_word,
   output logic [WORD_WIDTH-1:0] rsp_config_high_word,
   output logic                  rsp_lock_engaged
);

   logic            in_valid_ff, in_valid_in;
   gpio_access_type in_access_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   gpio_result_type rsp_result_ff;
   gpio_result_type result;
   logic            advance;
   logic            fire;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   gpio_regfile u_regfile (
      .clock       (clock),
      .reset       (reset),
      .access_fire (fire),
      .access      (in_access_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_access_ff.kind <= req_kind;
         in_access_ff.reg_select <= req_reg_select;
         in_access_ff.write_data <= req_write_data;
         in_access_ff.pin_levels <= req_pin_levels;
      end
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_result_ff.read_data;
   assign rsp_pin_drive = rsp_result_ff.pin_drive;
   assign rsp_config_low_word = rsp_result_ff.config_low_word;
   assign rsp_config_high_word = rsp_result_ff.config_high_word;
   assign rsp_lock_engaged = rsp_result_ff.lock_engaged;

endmodule

[src/gpio_regfile.sv]
// ----------------------------------------------------------------------------
// GPIO port register file
// Holds the port registers and the lock sequencer, and works out the result
// of one bus request from the current register values.
// ----------------------------------------------------------------------------
module gpio_regfile
   import gpio_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            access_fire,
   input  gpio_access_type access,
   output gpio_result_type result
);

   typedef enum logic [1:0] {
      LOCK_IDLE,
      LOCK_ARMED,
      LOCK_KEY_LOW,
      LOCK_READY
   } lock_step_type;

   logic [WORD_WIDTH-1:0] cfg_low_ff, cfg_low_in;
   logic [WORD_WIDTH-1:0] cfg_high_ff, cfg_high_in;
   logic [PIN_COUNT-1:0]  out_data_ff, out_data_in;
   logic [PIN_COUNT-1:0]  lock_mask_ff, lock_mask_in;
   lock_step_type         lock_step_ff, lock_step_in;
   logic                  lock_on_ff, lock_on_in;

   logic [WORD_WIDTH-1:0] read_data;
   logic [WORD_WIDTH-1:0] keep_low;
   logic [WORD_WIDTH-1:0] keep_high;
   logic [PIN_COUNT-1:0]  new_mask;
   logic                  new_key;
   logic                  same_mask;

   always_comb begin
      cfg_low_in = cfg_low_ff;
      cfg_high_in = cfg_high_ff;
      out_data_in = out_data_ff;
      lock_mask_in = lock_mask_ff;
      lock_step_in = lock_step_ff;
      lock_on_in = lock_on_ff;
      read_data = '0;
      new_mask = access.write_data[PIN_COUNT-1:0];
      new_key = access.write_data[KEY_BIT];
      same_mask = (new_mask == lock_mask_ff);
      keep_low = lock_on_ff ? nibble_mask(lock_mask_ff[7:0]) : '0;
      keep_high = lock_on_ff ? nibble_mask(lock_mask_ff[15:8]) : '0;

      if (access.kind == KIND_WRITE) begin
         unique case (access.reg_select)
            REG_CFG_LOW: begin
               cfg_low_in = (cfg_low_ff & keep_low) | (access.write_data & ~keep_low);
            end
            REG_CFG_HIGH: begin
               cfg_high_in = (cfg_high_ff & keep_high) | (access.write_data & ~keep_high);
            end
            REG_OUTPUT_DATA: begin
               out_data_in = access.write_data[PIN_COUNT-1:0];
            end
            REG_SET_RESET: begin
               out_data_in = (out_data_ff & ~access.write_data[WORD_WIDTH-1:PIN_COUNT])
                  | access.write_data[PIN_COUNT-1:0];
            end
            REG_RESET: begin
               out_data_in = out_data_ff & ~access.write_data[PIN_COUNT-1:0];
            end
            REG_LOCK: begin
               if (!lock_on_ff) begin
                  lock_mask_in = new_mask;
                  if (lock_step_ff == LOCK_ARMED && !new_key && same_mask) begin
                     lock_step_in = LOCK_KEY_LOW;
                  end else if (lock_step_ff == LOCK_KEY_LOW && new_key && same_mask) begin
                     lock_step_in = LOCK_READY;
                  end else begin
                     lock_step_in = new_key ? LOCK_ARMED : LOCK_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end else begin
         unique case (access.reg_select)
            REG_CFG_LOW:     read_data = cfg_low_ff;
            REG_CFG_HIGH:    read_data = cfg_high_ff;
            REG_INPUT_DATA:  read_data = {{(WORD_WIDTH-PIN_COUNT){1'b0}}, access.pin_levels};
            REG_OUTPUT_DATA: read_data = {{(WORD_WIDTH-PIN_COUNT){1'b0}}, out_data_ff};
            REG_LOCK: begin
               read_data = {{(WORD_WIDTH-PIN_COUNT){1'b0}}, lock_mask_ff};
               if (lock_on_ff) begin
                  read_data[KEY_BIT] = 1'b1;
               end else begin
                  lock_on_in = (lock_step_ff == LOCK_READY);
                  lock_step_in = LOCK_IDLE;
               end
            end
            default: read_data = '0;
         endcase
      end

      result.read_data = read_data;
      result.pin_drive = out_data_in;
      result.config_low_word = cfg_low_in;
      result.config_high_word = cfg_high_in;
      result.lock_engaged = lock_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_low_ff <= CFG_RESET;
         cfg_high_ff <= CFG_RESET;
         out_data_ff <= '0;
         lock_mask_ff <= '0;
         lock_step_ff <= LOCK_IDLE;
         lock_on_ff <= 1'b0;
      end else if (access_fire) begin
         cfg_low_ff <= cfg_low_in;
         cfg_high_ff <= cfg_high_in;
         out_data_ff <= out_data_in;
         lock_mask_ff <= lock_mask_in;
         lock_step_ff <= lock_step_in;
         lock_on_ff <= lock_on_in;
      end
   end

endmodule

[src/gpio_checker.sv]
// ----------------------------------------------------------------------------
// GPIO port checker
// Port-level checks on the GPIO port register block, bound to the top level.
// ----------------------------------------------------------------------------
module gpio_checker
   import gpio_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WORD_WIDTH-1:0] rsp_read_data,
   input logic                  rsp_lock_engaged
);

   // A stalled response holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data))
      else $error("Stalled response changed.");

   // With no response pending the block always takes a request.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("Request stalled with the response side empty.");

   // Once the lock is reported engaged, it stays engaged until reset.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $past(rsp_lock_engaged) && $past(rsp_valid) |-> rsp_lock_engaged)
      else $error("Lock released without reset.");

   // No response appears in the cycle right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Response present right after reset.");

endmodule

bind gpio_port_register_block_core gpio_checker u_gpio_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_data    (rsp_read_data),
   .rsp_lock_engaged (rsp_lock_engaged)
);

[verif/gpio_port_register_block_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO port response checker
// Forecasts the response of every accepted request from a private copy of
// the port registers and the lock sequence, and matches each response that
// the block hands out against the oldest forecast, field by field.
// ----------------------------------------------------------------------------
module gpio_port_register_block_checker
   import gpio_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_kind,
   input  logic [2:0]            req_reg_select,
   input  logic [WORD_WIDTH-1:0] req_write_data,
   input  logic [PIN_COUNT-1:0]  req_pin_levels,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [WORD_WIDTH-1:0] rsp_read_data,
   input  logic [PIN_COUNT-1:0]  rsp_pin_drive,
   input  logic [WORD_WIDTH-1:0] rsp_config_low_word,
   input  logic [WORD_WIDTH-1:0] rsp_config_high_word,
   input  logic                  rsp_lock_engaged,
   output int                    fail_count,
   output int                    outstanding,
   output int                    checked_count
);

   typedef enum logic [1:0] {
      LOCK_IDLE,
      LOCK_KEY_ONE,
      LOCK_KEY_ZERO,
      LOCK_KEY_ONE_AGAIN
   } lock_step_type;

   logic [WORD_WIDTH-1:0] cfg_low_q;
   logic [WORD_WIDTH-1:0] cfg_high_q;
   logic [PIN_COUNT-1:0]  drive_q;
   logic [PIN_COUNT-1:0]  lock_mask_q;
   lock_step_type         lock_step_q;
   logic                  locked_q;

   gpio_result_type awaited_responses[$];
   gpio_access_type seen_request;
   gpio_result_type due;

   function automatic logic [WORD_WIDTH-1:0] merge_config(input logic [WORD_WIDTH-1:0] held,
                                                          input logic [WORD_WIDTH-1:0] data,
                                                          input logic [7:0] pins);
      logic [WORD_WIDTH-1:0] keep;
      for (int b = 0; b < WORD_WIDTH; b++) begin
         keep[b] = locked_q && pins[b / 4];
      end
      return (held & keep) | (data & ~keep);
   endfunction

   function automatic gpio_result_type port_access_result(input gpio_access_type acc);
      gpio_result_type       res;
      logic [WORD_WIDTH-1:0] data;
      logic [PIN_COUNT-1:0]  mask;
      logic                  key;
      res = '0;
      data = acc.write_data;
      mask = data[PIN_COUNT-1:0];
      key = data[KEY_BIT];
      if (acc.kind == KIND_WRITE) begin
         case (acc.reg_select)
            REG_CFG_LOW: cfg_low_q = merge_config(cfg_low_q, data, lock_mask_q[7:0]);
            REG_CFG_HIGH: cfg_high_q = merge_config(cfg_high_q, data, lock_mask_q[15:8]);
            REG_OUTPUT_DATA: drive_q = data[15:0];
            REG_SET_RESET: drive_q = (drive_q & ~data[31:16]) | data[15:0];
            REG_RESET: drive_q = drive_q & ~data[15:0];
            REG_LOCK: begin
               if (!locked_q) begin
                  if (lock_step_q == LOCK_KEY_ONE && !key && mask == lock_mask_q) begin
                     lock_step_q = LOCK_KEY_ZERO;
                  end else if (lock_step_q == LOCK_KEY_ZERO && key && mask == lock_mask_q) begin
                     lock_step_q = LOCK_KEY_ONE_AGAIN;
                  end else begin
                     lock_step_q = key ? LOCK_KEY_ONE : LOCK_IDLE;
                  end
                  lock_mask_q = mask;
               end
            end
            default: ;
         endcase
      end else begin
         case (acc.reg_select)
            REG_CFG_LOW: res.read_data = cfg_low_q;
            REG_CFG_HIGH: res.read_data = cfg_high_q;
            REG_INPUT_DATA: res.read_data = {16'h0000, acc.pin_levels};
            REG_OUTPUT_DATA: res.read_data = {16'h0000, drive_q};
            REG_LOCK: begin
               res.read_data = {15'h0000, locked_q, lock_mask_q};
               if (!locked_q) begin
                  if (lock_step_q == LOCK_KEY_ONE_AGAIN) begin
                     locked_q = 1'b1;
                  end
                  lock_step_q = LOCK_IDLE;
               end
            end
            default: res.read_data = '0;
         endcase
      end
      res.pin_drive = drive_q;
      res.config_low_word = cfg_low_q;
      res.config_high_word = cfg_high_q;
      res.lock_engaged = locked_q;
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [WORD_WIDTH-1:0] want,
                                input logic [WORD_WIDTH-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, got %h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_low_q = CFG_RESET;
         cfg_high_q = CFG_RESET;
         drive_q = '0;
         lock_mask_q = '0;
         lock_step_q = LOCK_IDLE;
         locked_q = 1'b0;
         fail_count = 0;
         checked_count = 0;
         awaited_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("Response arrived with no request outstanding.");
               fail_count++;
            end else begin
               due = awaited_responses.pop_front();
               compare_field("read_data", due.read_data, rsp_read_data);
               compare_field("pin_drive", {16'h0000, due.pin_drive},
                             {16'h0000, rsp_pin_drive});
               compare_field("config_low_word", due.config_low_word, rsp_config_low_word);
               compare_field("config_high_word", due.config_high_word, rsp_config_high_word);
               compare_field("lock_engaged", {31'd0, due.lock_engaged},
                             {31'd0, rsp_lock_engaged});
               checked_count++;
            end
         end
         if (req_valid && !req_stall) begin
            seen_request.kind = req_kind;
            seen_request.reg_select = req_reg_select;
            seen_request.write_data = req_write_data;
            seen_request.pin_levels = req_pin_levels;
            awaited_responses.push_back(port_access_result(seen_request));
         end
      end
      outstanding = awaited_responses.size();
   end

endmodule

[verif/gpio_port_register_block_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO port register block testbench
// Drives directed and random register accesses, including intact and broken
// lock sequences, under three mixes of sender gaps and receiver stalls, and
// leaves the response checking to a companion checker.
// ----------------------------------------------------------------------------
module gpio_port_register_block_core_test
   import gpio_pkg::*;
();

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 200000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_kind;
   logic [2:0]            req_reg_select;
   logic [WORD_WIDTH-1:0] req_write_data;
   logic [PIN_COUNT-1:0]  req_pin_levels;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [WORD_WIDTH-1:0] rsp_read_data;
   logic [PIN_COUNT-1:0]  rsp_pin_drive;
   logic [WORD_WIDTH-1:0] rsp_config_low_word;
   logic [WORD_WIDTH-1:0] rsp_config_high_word;
   logic                  rsp_lock_engaged;

   int          fail_count;
   int          outstanding;
   int          checked_count;
   int          cycle_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   int unsigned accesses = 0;
   int unsigned reads = 0;
   int unsigned lock_attempts = 0;

   gpio_port_register_block_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_reg_select       (req_reg_select),
      .req_write_data       (req_write_data),
      .req_pin_levels       (req_pin_levels),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_read_data        (rsp_read_data),
      .rsp_pin_drive        (rsp_pin_drive),
      .rsp_config_low_word  (rsp_config_low_word),
      .rsp_config_high_word (rsp_config_high_word),
      .rsp_lock_engaged     (rsp_lock_engaged)
   );

   gpio_port_register_block_checker response_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_reg_select       (req_reg_select),
      .req_write_data       (req_write_data),
      .req_pin_levels       (req_pin_levels),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_read_data        (rsp_read_data),
      .rsp_pin_drive        (rsp_pin_drive),
      .rsp_config_low_word  (rsp_config_low_word),
      .rsp_config_high_word (rsp_config_high_word),
      .rsp_lock_engaged     (rsp_lock_engaged),
      .fail_count           (fail_count),
      .outstanding          (outstanding),
      .checked_count        (checked_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < rx_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input logic kind, input logic [2:0] sel,
                               input logic [WORD_WIDTH-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      req_reg_select = sel;
      req_write_data = data;
      req_pin_levels = 16'($urandom);
      do @(posedge clock); while (req_stall);
      accesses++;
      if (kind == KIND_READ) reads++;
      @(negedge clock);
   endtask

   function automatic logic [WORD_WIDTH-1:0] random_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 32'h0000_FFFF;
         3: return 32'hFFFF_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic lock_write(input logic key, input logic [PIN_COUNT-1:0] mask);
      send_request(KIND_WRITE, REG_LOCK, {15'($urandom), key, mask});
   endtask

   task automatic unrelated_access();
      logic [2:0] sel;
      sel = 3'($urandom_range(6));
      if (sel == REG_LOCK) sel = REG_UNUSED;
      send_request(1'($urandom), sel, random_word());
   endtask

   task automatic random_access();
      send_request(1'($urandom), 3'($urandom_range(7)), random_word());
   endtask

   // A broken attempt goes wrong at one step and is closed by a lock read.
   task automatic try_lock(input logic [PIN_COUNT-1:0] mask, input bit complete);
      int unsigned cut;
      int unsigned flaw;
      lock_attempts++;
      cut = complete ? 4 : $urandom_range(3, 1);
      for (int pos = 0; pos < 4; pos++) begin
         if (pos == cut) begin
            flaw = (pos == 3) ? $urandom_range(1) : $urandom_range(2);
            if (flaw == 0) begin
               lock_write((pos == 3) ? 1'($urandom) : (pos == 1), mask);
            end else if (flaw == 1) begin
               lock_write(pos != 1, mask ^ (16'd1 << $urandom_range(15)));
            end
            send_request(KIND_READ, REG_LOCK, $urandom);
            return;
         end
         case (pos)
            0: lock_write(1'b1, mask);
            1: lock_write(1'b0, mask);
            2: lock_write(1'b1, mask);
            default: send_request(KIND_READ, REG_LOCK, $urandom);
         endcase
         if (pos < 3 && $urandom_range(2) == 0) unrelated_access();
      end
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned stop_at;
      stop_at = accesses + count;
      while (accesses < stop_at) begin
         if ($urandom_range(5) == 0) try_lock(16'($urandom), 1'b0);
         else random_access();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_READ;
      req_reg_select = REG_CFG_LOW;
      req_write_data = '0;
      req_pin_levels = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 16;
      rx_stall_pct = 55;
      send_request(KIND_READ, REG_CFG_LOW, '1);
      send_request(KIND_READ, REG_CFG_HIGH, '0);
      send_request(KIND_WRITE, REG_CFG_LOW, '1);
      send_request(KIND_WRITE, REG_CFG_HIGH, '0);
      send_request(KIND_READ, REG_CFG_LOW, '0);
      send_request(KIND_READ, REG_CFG_HIGH, '0);
      send_request(KIND_WRITE, REG_CFG_LOW, '0);
      send_request(KIND_WRITE, REG_CFG_HIGH, '1);
      send_request(KIND_READ, REG_INPUT_DATA, '0);
      send_request(KIND_WRITE, REG_INPUT_DATA, '1);
      send_request(KIND_READ, REG_INPUT_DATA, '1);
      send_request(KIND_WRITE, REG_OUTPUT_DATA, '1);
      send_request(KIND_READ, REG_OUTPUT_DATA, '0);
      send_request(KIND_WRITE, REG_RESET, 32'hFFFF_0001);
      send_request(KIND_WRITE, REG_SET_RESET, 32'h00FF_00FF);
      send_request(KIND_WRITE, REG_SET_RESET, 32'hFFFF_0000);
      send_request(KIND_WRITE, REG_SET_RESET, 32'h0000_A5A5);
      send_request(KIND_READ, REG_SET_RESET, '1);
      send_request(KIND_READ, REG_RESET, '1);
      send_request(KIND_WRITE, REG_UNUSED, '1);
      send_request(KIND_READ, REG_UNUSED, '1);
      send_request(KIND_WRITE, REG_LOCK, 32'hFFFE_A5A5);
      send_request(KIND_READ, REG_LOCK, '0);
      random_phase(280);

      send_idle_pct = 55;
      rx_stall_pct = 16;
      random_phase(280);

      send_idle_pct = 0;
      rx_stall_pct = 0;
      try_lock(16'($urandom) | 16'h0101, 1'b1);
      random_phase(270);

      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Drove %0d register accesses (%0d reads), %0d lock sequences, three idle mixes.",
               accesses, reads, lock_attempts);
      $display("Compared %0d responses; the port lock was engaged for the final phase.",
               checked_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
